// ===== sv/nd_index_linearize_delinearize_core_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the index conversion core
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ND_INDEX_LINEARIZE_DELINEARIZE_CORE_ASSERT_SVH
`define ND_INDEX_LINEARIZE_DELINEARIZE_CORE_ASSERT_SVH

// same-cycle implication
`define NDL_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define NDL_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ndl_pkg.sv =====
// ---------------------------------------------------------------------------
// ndl_pkg
// Constants, codes and types shared by the index conversion core.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ndl_pkg;

	localparam int MAX_DIMS_DEF   = 4;
	localparam int COORD_BITS_DEF = 12;
	localparam int NUM_PORTS      = 4;
	localparam int FLAT_W         = 48;
	localparam int TOTAL_W        = 49;
	localparam int SIZE_W         = 13;
	localparam int DIMS_W         = 3;
	localparam int CFG_IDX_W      = 3;
	localparam int CFG_DATA_W     = 13;

	localparam logic CMD_LIN   = 1'b0;
	localparam logic CMD_DELIN = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_DIMS  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE3 = 3'd4;

	typedef struct packed {
		logic busy;
		logic done;
	} ndl_div_stat_t;

endpackage

// ===== sv/ndl_req_if.sv =====
// ---------------------------------------------------------------------------
// ndl_req_if
// Request channel: command, coordinates and linear index.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ndl_req_if #(
	parameter int COORD_BITS = ndl_pkg::COORD_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic                       command;
	logic [COORD_BITS-1:0]      coord_in0;
	logic [COORD_BITS-1:0]      coord_in1;
	logic [COORD_BITS-1:0]      coord_in2;
	logic [COORD_BITS-1:0]      coord_in3;
	logic [ndl_pkg::FLAT_W-1:0] flat_in;

	modport source (
		output valid, command, coord_in0, coord_in1, coord_in2, coord_in3, flat_in,
		input  ready
	);
	modport sink (
		input  valid, command, coord_in0, coord_in1, coord_in2, coord_in3, flat_in,
		output ready
	);
endinterface

// ===== sv/ndl_rsp_if.sv =====
// ---------------------------------------------------------------------------
// ndl_rsp_if
// Result channel: linear index, coordinates and error flag.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ndl_rsp_if #(
	parameter int COORD_BITS = ndl_pkg::COORD_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic [ndl_pkg::FLAT_W-1:0] flat_out;
	logic [COORD_BITS-1:0]      coord_out0;
	logic [COORD_BITS-1:0]      coord_out1;
	logic [COORD_BITS-1:0]      coord_out2;
	logic [COORD_BITS-1:0]      coord_out3;
	logic                       bad_index;

	modport source (
		output valid, flat_out, coord_out0, coord_out1, coord_out2, coord_out3, bad_index,
		input  ready
	);
	modport sink (
		input  valid, flat_out, coord_out0, coord_out1, coord_out2, coord_out3, bad_index,
		output ready
	);
endinterface

// ===== sv/ndl_cfg_if.sv =====
// ---------------------------------------------------------------------------
// ndl_cfg_if
// Configuration write channel: register index and write data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ndl_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [ndl_pkg::CFG_IDX_W-1:0]  index;
	logic [ndl_pkg::CFG_DATA_W-1:0] data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

// ===== sv/ndl_mac.sv =====
// ---------------------------------------------------------------------------
// ndl_mac
// Shared multiplier with registered, truncated product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ndl_mac #(
	parameter int AW = ndl_pkg::TOTAL_W,
	parameter int BW = ndl_pkg::SIZE_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [AW-1:0] a,
	input  logic [BW-1:0] b,
	output logic [AW-1:0] prod_q
);
	logic [AW+BW-1:0] full;

	assign full = {{BW{1'b0}}, a} * {{AW{1'b0}}, b};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= full[AW-1:0];
		end
	end
endmodule

// ===== sv/ndl_div.sv =====
// ---------------------------------------------------------------------------
// ndl_div
// Restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nd_index_linearize_delinearize_core_assert.svh"

module ndl_div #(
	parameter int W = ndl_pkg::FLAT_W
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [W-1:0]           dividend,
	input  logic [W-1:0]           divisor,
	output ndl_pkg::ndl_div_stat_t stat,
	output logic [W-1:0]           quot,
	output logic [W-1:0]           rem
);
	localparam int CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quot_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  div_q;
	logic [W:0]    rem_shift;
	logic          ge;
	logic [W:0]    rem_next;

	assign rem_shift = {rem_q, quot_q[W-1]};
	assign ge        = rem_shift >= {1'b0, div_q};
	assign rem_next  = ge ? (rem_shift - {1'b0, div_q}) : rem_shift;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			quot_q <= '0;
			rem_q  <= '0;
			div_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(W);
			quot_q <= dividend;
			rem_q  <= '0;
			div_q  <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[W-2:0], ge};
			rem_q  <= rem_next[W-1:0];
			cnt_q  <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;
	assign rem       = rem_q;

	`NDL_ASSERT_IMP(a_start_idle, start, !busy_q, "divider started while busy")
	`NDL_ASSERT_NXT(a_done_after_busy, busy_q && cnt_q == CW'(1), done_q && !busy_q,
		"divider missed its last step")
	`NDL_ASSERT_IMP(a_rem_below, done_q, (div_q == '0) || (rem_q < div_q),
		"remainder not below divisor")
endmodule

// ===== sv/nd_index_linearize_delinearize_core.sv =====
// ---------------------------------------------------------------------------
// nd_index_linearize_delinearize_core
// Column-major conversion between an N-dimensional coordinate and a linear
// index, on one shared multiplier and one bit-serial divider.
//
//   channel  role    word contents
//   -------  ------  ------------------------------------------------
//   req      sink    command, coord_in0..coord_in3, flat_in
//   rsp      source  flat_out, coord_out0..coord_out3, bad_index
//   cfg      sink    index, data (dims_in_use, size_dim0..size_dim3)
//
// Linearize sums each coordinate times its stride on the shared multiplier.
// Delinearize divides by each stride in turn, highest dimension first, on
// the one-bit-per-cycle divider. A config write recomputes the strides;
// req waits, also while a cfg word is offered; cfg waits while a req word
// is in work. One word is in flight; a finished word waits in the rsp
// register while the next req word is taken. Reset restores unit sizes,
// no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "nd_index_linearize_delinearize_core_assert.svh"

module nd_index_linearize_delinearize_core #(
	parameter int MAX_DIMS   = ndl_pkg::MAX_DIMS_DEF,
	parameter int COORD_BITS = ndl_pkg::COORD_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ndl_req_if.sink   req,
	ndl_rsp_if.source rsp,
	ndl_cfg_if.sink   cfg
);
	localparam int FW     = ndl_pkg::FLAT_W;
	localparam int TW     = ndl_pkg::TOTAL_W;
	localparam int SW     = ndl_pkg::SIZE_W;
	localparam int NP     = ndl_pkg::NUM_PORTS;
	localparam int KW     = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
	localparam int DIM_W  = $clog2(MAX_DIMS + 1);
	localparam int MW     = (COORD_BITS > SW) ? COORD_BITS : SW;
	localparam int CMP_W  = (COORD_BITS + 1 > SW) ? COORD_BITS + 1 : SW;
	localparam logic [CMP_W-1:0] SIZE_CAP = CMP_W'(1) << COORD_BITS;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RC_MUL,
		S_RC_WR,
		S_LIN_MUL,
		S_LIN_ACC,
		S_DL_CHK,
		S_DL_DIV,
		S_DL_WAIT,
		S_FIN
	} state_t;

	function automatic logic [SW-1:0] sat_size(input logic [SW-1:0] s);
		logic [SW-1:0] r;
		r = s;
		if (s == '0) begin
			r = SW'(1);
		end else if (CMP_W'(s) > SIZE_CAP) begin
			r = SW'(SIZE_CAP);
		end
		return r;
	endfunction

	state_t                    state_q;
	logic [KW-1:0]             k_q;
	logic [TW-1:0]             p_q;
	logic [TW-1:0]             total_q;
	logic [FW-1:0]             stride_q [MAX_DIMS];
	logic [SW-1:0]             size_q [MAX_DIMS];
	logic [ndl_pkg::DIMS_W-1:0] dims_q;
	logic [COORD_BITS-1:0]     coord_in_q [NP];
	logic [COORD_BITS-1:0]     coord_w_q [NP];
	logic [FW-1:0]             acc_q;
	logic [FW-1:0]             left_q;
	logic                      bad_q;
	logic                      rsp_valid_q;
	logic [FW-1:0]             flat_out_q;
	logic [COORD_BITS-1:0]     coord_out_q [NP];
	logic                      bad_out_q;

	logic                      cfg_wr;
	logic                      cfg_apply;
	logic [DIM_W-1:0]          n_act;
	logic [DIM_W-1:0]          lin_n;
	logic [COORD_BITS-1:0]     coord_sel;
	logic                      mac_en;
	logic [TW-1:0]             mac_a;
	logic [MW-1:0]             mac_b;
	logic [TW-1:0]             mac_prod;
	logic                      div_start;
	ndl_pkg::ndl_div_stat_t    div_stat;
	logic [FW-1:0]             div_quot;
	logic [FW-1:0]             div_rem;

	assign cfg.ready = (state_q == S_IDLE) || (state_q == S_RC_MUL) || (state_q == S_RC_WR);
	assign req.ready = (state_q == S_IDLE) && !cfg.valid;
	assign cfg_wr    = cfg.valid && cfg.ready;
	assign cfg_apply = cfg_wr && (cfg.index == ndl_pkg::REG_DIMS
		|| cfg.index == ndl_pkg::REG_SIZE0 || cfg.index == ndl_pkg::REG_SIZE1
		|| cfg.index == ndl_pkg::REG_SIZE2 || cfg.index == ndl_pkg::REG_SIZE3);

	always_comb begin
		if (dims_q == '0) begin
			n_act = DIM_W'(1);
		end else if (int'(dims_q) > MAX_DIMS) begin
			n_act = DIM_W'(MAX_DIMS);
		end else begin
			n_act = DIM_W'(dims_q);
		end
		lin_n = (int'(n_act) > NP) ? DIM_W'(NP) : n_act;
	end

	always_comb begin
		coord_sel = '0;
		for (int j = 0; j < NP; j++) begin
			if (int'(k_q) == j) begin
				coord_sel = coord_in_q[j];
			end
		end
	end

	always_comb begin
		mac_en = (state_q == S_RC_MUL) || (state_q == S_LIN_MUL);
		if (state_q == S_RC_MUL) begin
			mac_a = p_q;
			mac_b = MW'(size_q[k_q]);
		end else begin
			mac_a = {1'b0, stride_q[k_q]};
			mac_b = MW'(coord_sel);
		end
	end

	assign div_start = (state_q == S_DL_DIV) && (stride_q[k_q] != '0);

	ndl_mac #(
		.AW (TW),
		.BW (MW)
	) u_mac (
		.clk    (clk),
		.en     (mac_en),
		.a      (mac_a),
		.b      (mac_b),
		.prod_q (mac_prod)
	);

	ndl_div #(
		.W (FW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (left_q),
		.divisor  (stride_q[k_q]),
		.stat     (div_stat),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_q <= ndl_pkg::DIMS_W'(1);
			for (int j = 0; j < MAX_DIMS; j++) begin
				size_q[j] <= SW'(1);
			end
		end else if (cfg_wr) begin
			if (cfg.index == ndl_pkg::REG_DIMS) begin
				dims_q <= cfg.data[ndl_pkg::DIMS_W-1:0];
			end
			for (int j = 0; j < MAX_DIMS; j++) begin
				if (j < NP && int'(cfg.index) == int'(ndl_pkg::REG_SIZE0) + j) begin
					size_q[j] <= sat_size(cfg.data[SW-1:0]);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			p_q         <= TW'(1);
			total_q     <= TW'(1);
			acc_q       <= '0;
			left_q      <= '0;
			bad_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			flat_out_q  <= '0;
			bad_out_q   <= 1'b0;
			for (int j = 0; j < MAX_DIMS; j++) begin
				stride_q[j] <= FW'(1);
			end
			for (int j = 0; j < NP; j++) begin
				coord_in_q[j]  <= '0;
				coord_w_q[j]   <= '0;
				coord_out_q[j] <= '0;
			end
		end else begin
			if (rsp_valid_q && rsp.ready && state_q != S_FIN) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_apply) begin
				state_q <= S_RC_MUL;
				k_q     <= '0;
				p_q     <= TW'(1);
			end else begin
				case (state_q)
					S_IDLE: begin
						if (req.valid && req.ready) begin
							acc_q         <= '0;
							bad_q         <= 1'b0;
							k_q           <= '0;
							left_q        <= req.flat_in;
							coord_in_q[0] <= req.coord_in0;
							coord_in_q[1] <= req.coord_in1;
							coord_in_q[2] <= req.coord_in2;
							coord_in_q[3] <= req.coord_in3;
							for (int j = 0; j < NP; j++) begin
								coord_w_q[j] <= '0;
							end
							if (req.command == ndl_pkg::CMD_DELIN) begin
								state_q <= S_DL_CHK;
							end else begin
								state_q <= S_LIN_MUL;
							end
						end
					end
					S_RC_MUL: begin
						stride_q[k_q] <= p_q[FW-1:0];
						state_q       <= S_RC_WR;
					end
					S_RC_WR: begin
						p_q <= mac_prod;
						if (DIM_W'(k_q) + DIM_W'(1) == n_act) begin
							total_q <= mac_prod;
						end
						if (k_q == KW'(MAX_DIMS - 1)) begin
							state_q <= S_IDLE;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= S_RC_MUL;
						end
					end
					S_LIN_MUL: begin
						state_q <= S_LIN_ACC;
					end
					S_LIN_ACC: begin
						acc_q <= acc_q + mac_prod[FW-1:0];
						if (DIM_W'(k_q) + DIM_W'(1) == lin_n) begin
							state_q <= S_FIN;
						end else begin
							k_q     <= k_q + KW'(1);
							state_q <= S_LIN_MUL;
						end
					end
					S_DL_CHK: begin
						if ({1'b0, left_q} >= total_q) begin
							bad_q   <= 1'b1;
							state_q <= S_FIN;
						end else if (n_act == DIM_W'(1)) begin
							coord_w_q[0] <= left_q[COORD_BITS-1:0];
							state_q      <= S_FIN;
						end else begin
							k_q     <= KW'(n_act - DIM_W'(1));
							state_q <= S_DL_DIV;
						end
					end
					S_DL_DIV: begin
						if (stride_q[k_q] != '0) begin
							state_q <= S_DL_WAIT;
						end else if (k_q == KW'(1)) begin
							coord_w_q[0] <= left_q[COORD_BITS-1:0];
							state_q      <= S_FIN;
						end else begin
							k_q <= k_q - KW'(1);
						end
					end
					S_DL_WAIT: begin
						if (div_stat.done) begin
							left_q <= div_rem;
							for (int j = 0; j < NP; j++) begin
								if (int'(k_q) == j) begin
									coord_w_q[j] <= div_quot[COORD_BITS-1:0];
								end
							end
							if (k_q == KW'(1)) begin
								coord_w_q[0] <= div_rem[COORD_BITS-1:0];
								state_q      <= S_FIN;
							end else begin
								k_q     <= k_q - KW'(1);
								state_q <= S_DL_DIV;
							end
						end
					end
					S_FIN: begin
						if (!rsp_valid_q || rsp.ready) begin
							flat_out_q  <= acc_q;
							bad_out_q   <= bad_q;
							coord_out_q <= coord_w_q;
							rsp_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end
					end
					default: begin
						state_q <= S_IDLE;
					end
				endcase
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.flat_out   = flat_out_q;
	assign rsp.coord_out0 = coord_out_q[0];
	assign rsp.coord_out1 = coord_out_q[1];
	assign rsp.coord_out2 = coord_out_q[2];
	assign rsp.coord_out3 = coord_out_q[3];
	assign rsp.bad_index  = bad_out_q;

	`NDL_ASSERT_IMP(a_ready_div_idle, req.ready, !div_stat.busy,
		"request taken while divider busy")
	`NDL_ASSERT_IMP(a_bad_zero, rsp.valid && rsp.bad_index,
		rsp.flat_out == '0 && rsp.coord_out0 == '0 && rsp.coord_out1 == '0
		&& rsp.coord_out2 == '0 && rsp.coord_out3 == '0,
		"bad index word carries nonzero fields")
	`NDL_ASSERT_IMP(a_lin_coords_zero, rsp.valid && rsp.flat_out != '0,
		!rsp.bad_index && rsp.coord_out0 == '0 && rsp.coord_out1 == '0
		&& rsp.coord_out2 == '0 && rsp.coord_out3 == '0,
		"linearize word carries coordinates")
endmodule

// ===== test/nd_index_linearize_delinearize_checker.sv =====
// ---------------------------------------------------------------------------
// nd_index_linearize_delinearize_checker
// Watches the req, rsp and cfg channels of the index conversion core. Keeps
// its own copy of the dimension sizes, strides and total count, works out
// the result word of every accepted req word, and compares each accepted
// rsp word field by field with the oldest outstanding one.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nd_index_linearize_delinearize_checker
	import ndl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	ndl_req_if   req,
	ndl_rsp_if   rsp,
	ndl_cfg_if   cfg,
	output int   fail_count,
	output int   pending
);

	localparam int CB         = COORD_BITS_DEF;
	localparam int MAX_PRINTS = 200;

	typedef logic [CB-1:0] coord_t;
	typedef coord_t [NUM_PORTS-1:0] coord_vec_t;

	typedef struct packed {
		logic [FLAT_W-1:0] flat;
		coord_vec_t        coord;
		logic              bad;
	} conversion_t;

	logic [DIMS_W-1:0]  dims_reg;
	logic [SIZE_W-1:0]  dim_size [MAX_DIMS_DEF];
	logic [FLAT_W-1:0]  stride [MAX_DIMS_DEF];
	logic [TOTAL_W-1:0] total_count;
	conversion_t        expected_words [$];
	conversion_t        seen;
	conversion_t        want;
	int                 mismatches;

	function automatic int active_dims();
		if (dims_reg == '0)
			return 1;
		if (int'(dims_reg) > MAX_DIMS_DEF)
			return MAX_DIMS_DEF;
		return int'(dims_reg);
	endfunction

	function automatic void rebuild_strides();
		logic [TOTAL_W-1:0] prod;
		int n;
		n = active_dims();
		prod = TOTAL_W'(1);
		for (int i = 0; i < MAX_DIMS_DEF; i++) begin
			stride[i] = prod[FLAT_W-1:0];
			prod = prod * TOTAL_W'(dim_size[i]);
			if (i + 1 == n)
				total_count = prod;
		end
	endfunction

	function automatic void apply_reg_write(logic [CFG_IDX_W-1:0] idx,
			logic [CFG_DATA_W-1:0] value);
		logic [SIZE_W-1:0] s;
		if (idx == REG_DIMS) begin
			dims_reg = value[DIMS_W-1:0];
		end else if (idx >= REG_SIZE0 && idx <= REG_SIZE3) begin
			s = SIZE_W'(value);
			if (s == '0)
				s = SIZE_W'(1);
			if (s > SIZE_W'(1 << CB))
				s = SIZE_W'(1 << CB);
			dim_size[int'(idx - REG_SIZE0)] = s;
		end else begin
			return;
		end
		rebuild_strides();
	endfunction

	function automatic conversion_t convert_word(logic cmd, coord_vec_t cin,
			logic [FLAT_W-1:0] flat_in);
		conversion_t r;
		logic [63:0] acc;
		logic [63:0] left;
		logic [63:0] q;
		int n;
		r = '0;
		n = active_dims();
		if (cmd == CMD_LIN) begin
			acc = '0;
			for (int i = 0; i < n; i++)
				acc += 64'(cin[i]) * 64'(stride[i]);
			r.flat = acc[FLAT_W-1:0];
		end else if (64'(flat_in) >= 64'(total_count)) begin
			r.bad = 1'b1;
		end else begin
			left = 64'(flat_in);
			for (int i = n - 1; i >= 1; i--) begin
				q = '0;
				if (stride[i] != '0) begin
					q = left / 64'(stride[i]);
					left = left % 64'(stride[i]);
				end
				r.coord[i] = q[CB-1:0];
			end
			r.coord[0] = left[CB-1:0];
		end
		return r;
	endfunction

	function automatic void note_mismatch(string field, logic [FLAT_W-1:0] exp_val,
			logic [FLAT_W-1:0] act_val);
		if (mismatches < MAX_PRINTS)
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, exp_val,
				act_val);
		mismatches++;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dims_reg = DIMS_W'(1);
			for (int i = 0; i < MAX_DIMS_DEF; i++)
				dim_size[i] = SIZE_W'(1);
			rebuild_strides();
			expected_words.delete();
			mismatches = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (req.valid && req.ready)
				expected_words.push_back(convert_word(req.command,
					{req.coord_in3, req.coord_in2, req.coord_in1, req.coord_in0},
					req.flat_in));
			if (rsp.valid && rsp.ready) begin
				seen.flat  = rsp.flat_out;
				seen.coord = {rsp.coord_out3, rsp.coord_out2, rsp.coord_out1, rsp.coord_out0};
				seen.bad   = rsp.bad_index;
				if (expected_words.size() == 0) begin
					if (mismatches < MAX_PRINTS)
						$display("%0t: rsp word with none outstanding, expected none, actual %h",
							$time, seen);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (seen.flat !== want.flat)
						note_mismatch("flat_out", want.flat, seen.flat);
					for (int i = 0; i < NUM_PORTS; i++)
						if (seen.coord[i] !== want.coord[i])
							note_mismatch($sformatf("coord_out%0d", i), FLAT_W'(want.coord[i]),
								FLAT_W'(seen.coord[i]));
					if (seen.bad !== want.bad)
						note_mismatch("bad_index", FLAT_W'(want.bad), FLAT_W'(seen.bad));
				end
			end
			if (cfg.valid && cfg.ready)
				apply_reg_write(cfg.index, cfg.data);
			fail_count <= mismatches;
			pending <= expected_words.size();
		end
	end

endmodule

// ===== test/nd_index_linearize_delinearize_core_tb.sv =====
// ---------------------------------------------------------------------------
// nd_index_linearize_delinearize_core_tb
// Drives the index conversion core through a directed set of corner words
// and then phases of random words under changing shapes, with random gaps
// on all channels; the checker predicts and compares every result word.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module nd_index_linearize_delinearize_core_tb;
	import ndl_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 200;
	localparam int PHASE_WORDS    = 75;
	localparam int RANDOM_PHASES  = 14;
	localparam int IDLE_PCT       = 37;
	localparam int SIZE_MAX       = 1 << COORD_BITS_DEF;

	typedef logic [COORD_BITS_DEF-1:0] coord_t;

	logic               clk;
	logic               arst_n;
	logic               steady;
	int                 fail_count;
	int                 pending;
	int                 idle_cycles;
	int                 shape_dims;
	int                 shape_size [MAX_DIMS_DEF];
	logic [TOTAL_W-1:0] index_span;

	ndl_req_if req ();
	ndl_rsp_if rsp ();
	ndl_cfg_if cfg ();

	nd_index_linearize_delinearize_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	nd_index_linearize_delinearize_checker i_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.rsp        (rsp),
		.cfg        (cfg),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	initial begin
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("Verification failed");
		$finish;
	end

	task automatic send_word(input logic cmd, input coord_t c0, input coord_t c1,
			input coord_t c2, input coord_t c3, input logic [FLAT_W-1:0] flat);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid     <= 1'b1;
		req.command   <= cmd;
		req.coord_in0 <= c0;
		req.coord_in1 <= c1;
		req.coord_in2 <= c2;
		req.coord_in3 <= c3;
		req.flat_in   <= flat;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			cfg.valid <= 1'b0;
			@(posedge clk);
		end
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= value;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
	endtask

	// drop valid and hold until every outstanding word has come back
	task automatic drain_words();
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// odd encodings: zero for one, over-range for the maximum, junk upper bits
	task automatic set_shape(input int dims, input int sizes [MAX_DIMS_DEF], input bit odd);
		logic [CFG_DATA_W-1:0] code;
		code = CFG_DATA_W'(dims);
		if (odd) begin
			code[CFG_DATA_W-1:DIMS_W] = (CFG_DATA_W - DIMS_W)'($urandom);
			if (dims == 1)
				code[DIMS_W-1:0] = '0;
			else if (dims == MAX_DIMS_DEF)
				code[DIMS_W-1:0] = DIMS_W'($urandom_range(7, 5));
		end
		write_reg(REG_DIMS, code);
		for (int i = 0; i < MAX_DIMS_DEF; i++) begin
			code = CFG_DATA_W'(sizes[i]);
			if (odd && sizes[i] == 1)
				code = '0;
			else if (odd && sizes[i] == SIZE_MAX)
				code = CFG_DATA_W'($urandom_range(8191, SIZE_MAX + 1));
			write_reg(REG_SIZE0 + CFG_IDX_W'(i), code);
		end
		if (odd)
			write_reg(REG_SIZE3 + CFG_IDX_W'($urandom_range(3, 1)), CFG_DATA_W'($urandom));
		cfg.valid <= 1'b0;
		shape_dims = dims;
		index_span = TOTAL_W'(1);
		for (int i = 0; i < MAX_DIMS_DEF; i++) begin
			shape_size[i] = sizes[i];
			if (i < dims)
				index_span = index_span * TOTAL_W'(sizes[i]);
		end
	endtask

	task automatic send_random();
		logic [63:0]       r;
		logic [FLAT_W-1:0] flat;
		coord_t            c [MAX_DIMS_DEF];
		int                sel;
		r = {$urandom, $urandom};
		for (int i = 0; i < MAX_DIMS_DEF; i++) begin
			if ($urandom_range(4) != 0)
				c[i] = coord_t'($urandom_range(shape_size[i] - 1, 0));
			else
				c[i] = coord_t'($urandom);
		end
		sel = $urandom_range(9);
		if (sel < 6)
			flat = FLAT_W'(r % 64'(index_span));
		else if (sel == 6)
			flat = FLAT_W'(index_span - 1);
		else if (sel == 7)
			flat = FLAT_W'(index_span);
		else if (sel == 8)
			flat = FLAT_W'(index_span + TOTAL_W'($urandom_range(3)));
		else
			flat = r[FLAT_W-1:0];
		send_word($urandom_range(1) ? CMD_DELIN : CMD_LIN, c[0], c[1], c[2], c[3], flat);
	endtask

	initial begin
		int sizes [MAX_DIMS_DEF];
		int sel;
		arst_n        <= 1'b0;
		steady        <= 1'b0;
		req.valid     <= 1'b0;
		req.command   <= CMD_LIN;
		req.coord_in0 <= '0;
		req.coord_in1 <= '0;
		req.coord_in2 <= '0;
		req.coord_in3 <= '0;
		req.flat_in   <= '0;
		cfg.valid     <= 1'b0;
		cfg.index     <= REG_DIMS;
		cfg.data      <= '0;
		shape_dims    = 1;
		shape_size    = '{1, 1, 1, 1};
		index_span    = TOTAL_W'(1);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset shape: one dimension of one element
		send_word(CMD_LIN, '1, '1, '1, '1, '0);
		send_word(CMD_DELIN, '1, '1, '1, '1, '0);
		send_word(CMD_DELIN, '0, '0, '0, '0, FLAT_W'(1));
		send_word(CMD_DELIN, '0, '0, '0, '0, '1);
		drain_words();

		set_shape(MAX_DIMS_DEF, '{SIZE_MAX, SIZE_MAX, SIZE_MAX, SIZE_MAX}, 1'b0);
		send_word(CMD_LIN, '1, '1, '1, '1, '0);
		send_word(CMD_LIN, '0, '0, '0, '0, '1);
		send_word(CMD_DELIN, '0, '0, '0, '0, '1);
		send_word(CMD_DELIN, '1, '1, '1, '1, '0);
		send_word(CMD_DELIN, '0, '0, '0, '0, 48'h5555_5555_5555);
		send_word(CMD_DELIN, '0, '0, '0, '0, 48'hAAAA_AAAA_AAAA);
		drain_words();

		set_shape(1, '{SIZE_MAX, 1, 7, SIZE_MAX}, 1'b1);
		send_word(CMD_LIN, '1, '1, '1, '1, '0);
		send_word(CMD_DELIN, '0, '0, '0, '0, FLAT_W'(SIZE_MAX - 1));
		send_word(CMD_DELIN, '0, '0, '0, '0, FLAT_W'(SIZE_MAX));
		drain_words();

		set_shape(MAX_DIMS_DEF, '{3, 1, 5, SIZE_MAX}, 1'b1);
		send_word(CMD_LIN, '1, '1, '1, '1, '0);
		send_word(CMD_LIN, coord_t'(2), '0, coord_t'(4), '1, '0);
		send_word(CMD_DELIN, '0, '0, '0, '0, FLAT_W'(index_span - 1));
		send_word(CMD_DELIN, '0, '0, '0, '0, FLAT_W'(index_span));
		send_word(CMD_DELIN, '0, '0, '0, '0, FLAT_W'(12345));
		drain_words();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			for (int i = 0; i < MAX_DIMS_DEF; i++) begin
				sel = $urandom_range(9);
				if (p == 0)
					sizes[i] = SIZE_MAX;
				else if (p == 1 || sel == 0)
					sizes[i] = 1;
				else if (sel == 1)
					sizes[i] = SIZE_MAX;
				else if (sel < 7)
					sizes[i] = $urandom_range(16, 2);
				else
					sizes[i] = $urandom_range(SIZE_MAX, 2);
			end
			set_shape((p < 2) ? MAX_DIMS_DEF : $urandom_range(MAX_DIMS_DEF, 1), sizes,
				$urandom_range(2) == 0);
			if (p == 2)
				steady <= 1'b1;
			repeat (PHASE_WORDS) send_random();
			if (p == 2)
				steady <= 1'b0;
			drain_words();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
